/* src/dmpc_pkg.sv */
// Shared types, constants and helpers for the dual motor PWM mode controller.
package dmpc_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MOTION = 2'd1;
    localparam logic [1:0] CMD_ARM    = 2'd2;

    localparam logic [3:0] MODE_STOP       = 4'd0;
    localparam logic [3:0] MODE_FWD        = 4'd1;
    localparam logic [3:0] MODE_REV        = 4'd2;
    localparam logic [3:0] MODE_LEFT_FWD   = 4'd3;
    localparam logic [3:0] MODE_RIGHT_FWD  = 4'd4;
    localparam logic [3:0] MODE_RIGHT_REV  = 4'd5;
    localparam logic [3:0] MODE_LEFT_REV   = 4'd6;
    localparam logic [3:0] MODE_SPIN_RIGHT = 4'd7;
    localparam logic [3:0] MODE_SPIN_LEFT  = 4'd8;

    localparam logic [3:0] CODE_MODE_MAX = 4'd8;
    localparam logic [3:0] CODE_CURVE_RF = 4'd9;
    localparam logic [3:0] CODE_CURVE_LF = 4'd10;
    localparam logic [3:0] CODE_CURVE_RR = 4'd11;
    localparam logic [3:0] CODE_CURVE_LR = 4'd12;

    localparam logic [6:0]  PHASE_TOP     = 7'd99;
    localparam logic [3:0]  TICK_TOP      = 4'd9;
    localparam logic [6:0]  LEVEL_MAX     = 7'd100;
    localparam logic [6:0]  RAMP_BASE     = 7'd101;
    localparam logic [3:0]  RAMP_LAST     = 4'd9;
    localparam logic [3:0]  RAMP_DEN      = 4'd14;
    localparam logic [14:0] DEFAULT_LIMIT = 15'd10;

    // floor(x/14) = (x * 586) >> 13, exact for x < 683
    localparam logic [9:0]  RECIP14  = 10'd586;
    // floor(x/100) = (x * 10486) >> 20, exact for x < 43690
    localparam logic [13:0] RECIP100 = 14'd10486;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  code;
        logic [6:0]  speed;       // clamped
        logic [6:0]  accel;       // clamped
        logic [14:0] limit;       // zero already replaced by default
        logic [13:0] inner_prod;  // speed * (100 - rate)
        logic [6:0]  ramp_q0;     // 5*speed / 14
        logic [3:0]  ramp_r0;     // 5*speed % 14
        logic [2:0]  tgt_q;       // speed / 14
        logic [3:0]  tgt_r;       // speed % 14
    } item_t;

    typedef struct packed {
        logic       armed;
        logic [6:0] right;
        logic [6:0] left;
        logic [3:0] mode;
        logic [3:0] lines;
    } result_t;

    function automatic logic [6:0] clamp_level(input logic [6:0] v);
        return (v > LEVEL_MAX) ? LEVEL_MAX : v;
    endfunction

    function automatic logic [5:0] div14(input logic [8:0] x);
        logic [18:0] p;
        p = x * RECIP14;
        return p[18:13];
    endfunction

endpackage

/* src/dmpc_in_stage.sv */
// Input register with the stateless precomputation of each transaction.
module dmpc_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    input  logic                 take,
    output logic                 item_vld,
    output dmpc_pkg::item_t      item
);
    import dmpc_pkg::*;

    logic        vld_reg, vld_next;
    item_t       item_reg, item_next;
    logic [6:0]  spd_c, rate_c, acc_c;
    logic [8:0]  spd5;
    logic [5:0]  q5, qs;
    logic [8:0]  q5x14;
    logic [8:0]  qsx14;
    logic [14:0] lim_raw;

    always_comb begin
        spd_c   = clamp_level(s_axis_tdata[10:4]);
        rate_c  = clamp_level(s_axis_tdata[17:11]);
        acc_c   = clamp_level(s_axis_tdata[24:18]);
        lim_raw = s_axis_tdata[39:25];
        spd5    = {spd_c, 2'b00} + {2'b00, spd_c};
        q5      = div14(spd5);
        qs      = div14({2'b00, spd_c});
        q5x14   = {q5, 3'b000} + {1'b0, q5, 2'b00} + {2'b00, q5, 1'b0};
        qsx14   = {qs, 3'b000} + {1'b0, qs, 2'b00} + {2'b00, qs, 1'b0};

        item_next.cmd        = s_axis_tuser;
        item_next.code       = s_axis_tdata[3:0];
        item_next.speed      = spd_c;
        item_next.accel      = acc_c;
        item_next.limit      = (lim_raw == '0) ? DEFAULT_LIMIT : lim_raw;
        item_next.inner_prod = spd_c * (LEVEL_MAX - rate_c);
        item_next.ramp_q0    = {1'b0, q5};
        item_next.ramp_r0    = 4'(spd5 - q5x14);
        item_next.tgt_q      = qs[2:0];
        item_next.tgt_r      = 4'({2'b00, spd_c} - qsx14);
    end

    assign s_axis_tready = !vld_reg || take;
    assign vld_next      = s_axis_tvalid || (vld_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_next;
        end
    end

    assign item_vld = vld_reg;
    assign item     = item_reg;

endmodule

/* src/dmpc_core.sv */
// Controller state, per-transaction update and result register.
module dmpc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_vld,
    input  dmpc_pkg::item_t      item,
    output logic                 take,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output dmpc_pkg::result_t    res
);
    import dmpc_pkg::*;

    logic [6:0]  phase_reg, phase_next;
    logic [3:0]  ones_reg, ones_next;
    logic [6:0]  left_reg, left_next;
    logic [6:0]  right_reg, right_next;
    logic [3:0]  mode_reg, mode_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [14:0] limit_reg, limit_next;
    logic        auto_reg, auto_next;
    logic        ramp_on_reg, ramp_on_next;
    logic [3:0]  step_reg, step_next;
    logic [6:0]  sub_reg, sub_next;
    logic [6:0]  div_reg, div_next;
    logic [3:0]  rem_reg, rem_next;
    logic [2:0]  tq_reg, tq_next;
    logic [3:0]  tr_reg, tr_next;
    logic        out_vld_reg;
    result_t     res_reg, res_next;

    logic [6:0]  sub_sum;
    logic [4:0]  rem_sum;
    logic        carry;
    logic [27:0] inner_full;
    logic [6:0]  inner;

    function automatic logic [3:0] drive_lines(input logic [6:0] ph, input logic [6:0] l,
                                               input logic [6:0] r, input logic [3:0] m);
        logic [3:0] ln;
        logic       lon, ron;
        ln  = 4'hF;
        lon = l > ph;
        ron = r > ph;
        if (lon && (m inside {MODE_REV, MODE_LEFT_REV, MODE_SPIN_LEFT}))   ln[0] = 1'b0;
        if (lon && (m inside {MODE_FWD, MODE_LEFT_FWD, MODE_SPIN_RIGHT}))  ln[1] = 1'b0;
        if (ron && (m inside {MODE_REV, MODE_RIGHT_REV, MODE_SPIN_RIGHT})) ln[2] = 1'b0;
        if (ron && (m inside {MODE_FWD, MODE_RIGHT_FWD, MODE_SPIN_LEFT}))  ln[3] = 1'b0;
        return ln;
    endfunction

    assign take       = item_vld && (!out_vld_reg || m_axis_tready);
    assign inner_full = item.inner_prod * RECIP100;
    assign inner      = inner_full[26:20];

    always_comb begin
        phase_next   = phase_reg;
        ones_next    = ones_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        limit_next   = limit_reg;
        auto_next    = auto_reg;
        ramp_on_next = ramp_on_reg;
        step_next    = step_reg;
        sub_next     = sub_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        tq_next      = tq_reg;
        tr_next      = tr_reg;
        sub_sum      = sub_reg + 7'd1;
        rem_sum      = {1'b0, rem_reg} + {1'b0, tr_reg};
        carry        = rem_sum >= {1'b0, RAMP_DEN};
        res_next     = '0;

        if (item.cmd == CMD_TICK) begin
            phase_next     = (phase_reg >= PHASE_TOP) ? 7'd0 : phase_reg + 7'd1;
            ones_next      = (ones_reg >= TICK_TOP) ? 4'd0 : ones_reg + 4'd1;
            res_next.lines = drive_lines(phase_next, left_reg, right_reg, mode_reg);
            if (ones_next == 4'd0) begin
                if (elapsed_reg != '0 && elapsed_reg != '1) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
                if (ramp_on_reg) begin
                    sub_next = sub_sum;
                    if (sub_sum >= div_reg) begin
                        sub_next   = '0;
                        step_next  = (step_reg < RAMP_LAST) ? step_reg + 4'd1 : step_reg;
                        rem_next   = carry ? 4'(rem_sum - {1'b0, RAMP_DEN}) : rem_sum[3:0];
                        left_next  = left_reg + {4'd0, tq_reg} + {6'd0, carry};
                        right_next = left_reg + {4'd0, tq_reg} + {6'd0, carry};
                        if (step_next >= RAMP_LAST) begin
                            ramp_on_next = 1'b0;
                        end
                    end
                end
            end
            if (auto_reg && (elapsed_next > {1'b0, limit_reg})) begin
                elapsed_next = '0;
                limit_next   = '0;
                mode_next    = MODE_STOP;
                auto_next    = 1'b0;
            end
        end else begin
            if (item.cmd == CMD_MOTION) begin
                if (item.code <= CODE_MODE_MAX) begin
                    mode_next = item.code;
                    if (elapsed_reg != '0) begin
                        elapsed_next = 16'd1;
                    end
                    if (item.accel != '0) begin
                        ramp_on_next = 1'b1;
                        step_next    = '0;
                        sub_next     = '0;
                        div_next     = RAMP_BASE - item.accel;
                        tq_next      = item.tgt_q;
                        tr_next      = item.tgt_r;
                        rem_next     = item.ramp_r0;
                        left_next    = item.ramp_q0;
                        right_next   = item.ramp_q0;
                    end else begin
                        ramp_on_next = 1'b0;
                        left_next    = item.speed;
                        right_next   = item.speed;
                    end
                end else if (item.code <= CODE_CURVE_LR) begin
                    ramp_on_next = 1'b0;
                    mode_next    = (item.code <= CODE_CURVE_LF) ? MODE_FWD : MODE_REV;
                    if (item.code == CODE_CURVE_RF || item.code == CODE_CURVE_RR) begin
                        left_next  = item.speed;
                        right_next = inner;
                    end else begin
                        left_next  = inner;
                        right_next = item.speed;
                    end
                end else begin
                    mode_next = MODE_STOP;
                end
            end else if (item.cmd == CMD_ARM) begin
                limit_next   = item.limit;
                elapsed_next = 16'd1;
                auto_next    = 1'b1;
            end
            if (mode_next == MODE_STOP) begin
                left_next    = '0;
                right_next   = '0;
                ramp_on_next = 1'b0;
            end
            res_next.lines = drive_lines(phase_reg, left_next, right_next, mode_next);
        end

        if (mode_next == MODE_STOP) begin
            left_next    = '0;
            right_next   = '0;
            ramp_on_next = 1'b0;
        end

        res_next.mode  = mode_next;
        res_next.left  = left_next;
        res_next.right = right_next;
        res_next.armed = auto_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            ones_reg    <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            mode_reg    <= MODE_STOP;
            elapsed_reg <= '0;
            limit_reg   <= '0;
            auto_reg    <= 1'b0;
            ramp_on_reg <= 1'b0;
            step_reg    <= '0;
            sub_reg     <= '0;
            div_reg     <= RAMP_BASE;
            rem_reg     <= '0;
            tq_reg      <= '0;
            tr_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg   <= phase_next;
                ones_reg    <= ones_next;
                left_reg    <= left_next;
                right_reg   <= right_next;
                mode_reg    <= mode_next;
                elapsed_reg <= elapsed_next;
                limit_reg   <= limit_next;
                auto_reg    <= auto_next;
                ramp_on_reg <= ramp_on_next;
                step_reg    <= step_next;
                sub_reg     <= sub_next;
                div_reg     <= div_next;
                rem_reg     <= rem_next;
                tq_reg      <= tq_next;
                tr_reg      <= tr_next;
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign res           = res_reg;

    a_stop_clears_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STOP) |-> (left_reg == '0 && right_reg == '0 && !ramp_on_reg))
        else $error("stopped mode with nonzero level or live ramp");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg <= LEVEL_MAX && right_reg <= LEVEL_MAX))
        else $error("wheel level above full scale");

    a_phase_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg <= PHASE_TOP && {3'd0, ones_reg} == phase_reg % 7'd10))
        else $error("millisecond divider out of step with phase");

    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !auto_reg |-> (elapsed_reg == '0 && limit_reg == '0))
        else $error("timer state left over while disarmed");

    a_ramp_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_on_reg |-> (rem_reg < RAMP_DEN && step_reg < RAMP_LAST && left_reg == right_reg))
        else $error("ramp bookkeeping inconsistent");

    a_result_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending result dropped");

endmodule

/* src/dual_motor_pwm_mode_controller_unit.sv */
// Top level of the dual motor PWM mode controller.
//
//  channel  dir  fields (tdata / tuser, lowest bit first)
//  s_axis   in   tdata: motion_code, speed, curve_rate, accel, stop_after_ms; tuser: command
//  m_axis   out  tdata: drive_lines, drive_mode, left_level, right_level, timer_armed
//
// One transaction per cycle while the result is not stalled; each transaction passes
// through the input register, then the state update into the result register.
// Reset clears all control state; the ramp divisor resets to 101.
// A stalled result holds the state update; the input register keeps
// accepting while the result register can drain in the same cycle.
module dual_motor_pwm_mode_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // motion_code[3:0], speed[10:4], curve_rate[17:11],
                                        // accel[24:18], stop_after_ms[39:25]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // drive_lines[3:0], drive_mode[7:4], left_level[14:8],
                                        // right_level[21:15], timer_armed[22], zero[23]
);
    import dmpc_pkg::*;

    item_t   item;
    result_t res;
    logic    item_vld;
    logic    take;

    dmpc_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_vld      (item_vld),
        .item          (item)
    );

    dmpc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_vld      (item_vld),
        .item          (item),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .res           (res)
    );

    assign m_axis_tdata = {1'b0, res};

endmodule

/* verif/tb_top.sv */
// Self-checking stream testbench for the dual motor PWM mode controller.
`timescale 1ns / 1ps

module tb_top;
    import dmpc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MS_TICKS     = 10;
    localparam int RANDOM_ITEMS = 1250;
    localparam int PHASE_LEN    = 160;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {PH_CLEAN, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_e;

    typedef struct {
        logic [1:0]  cmd;
        logic [39:0] data;
    } cmd_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // motion_code, speed, curve_rate, accel, stop_after_ms
    logic [1:0]  s_axis_tuser = '0;   // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // drive_lines, drive_mode, left_level, right_level,
                                      // timer_armed, zero pad

    dual_motor_pwm_mode_controller_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 aclk = ~aclk;

    cmd_item_t   pending_q[$];
    result_t     drive_expect_q[$];
    cmd_item_t   nxt;
    int          sent_cnt = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;
    int          n_tick = 0, n_motion = 0, n_arm = 0, n_autostop = 0, n_ramp = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    idle_phase_e idle_phase;
    int          src_idle_pct, snk_stall_pct;

    assign idle_phase    = idle_phase_e'((sent_cnt / PHASE_LEN) % 4);
    assign src_idle_pct  = (idle_phase == PH_SRC_IDLE) ? 69 : (idle_phase == PH_BOTH) ? 21 : 0;
    assign snk_stall_pct = (idle_phase == PH_SNK_STALL) ? 69 : (idle_phase == PH_BOTH) ? 21 : 0;

    // motor state mirror
    logic [6:0]  pwm_phase   = '0;
    logic [6:0]  duty_l      = '0;
    logic [6:0]  duty_r      = '0;
    logic [3:0]  mode_now    = MODE_STOP;
    logic [15:0] ms_count    = '0;
    logic [15:0] ms_limit    = '0;
    logic        stop_armed  = 1'b0;
    logic        ramping     = 1'b0;
    logic [3:0]  ramp_idx    = '0;
    logic [6:0]  ramp_tick   = '0;
    logic [6:0]  ramp_period = RAMP_BASE;
    logic [6:0]  ramp_goal   = '0;

    function automatic int pct_limit(input logic [6:0] v);
        return (v > LEVEL_MAX) ? int'(LEVEL_MAX) : int'(v);
    endfunction

    function automatic logic [3:0] line_pattern();
        logic [3:0] l;
        logic       lon, ron;
        l   = 4'hF;
        lon = duty_l > pwm_phase;
        ron = duty_r > pwm_phase;
        if (lon && (mode_now == MODE_REV || mode_now == MODE_LEFT_REV ||
                    mode_now == MODE_SPIN_LEFT)) l[0] = 1'b0;
        if (lon && (mode_now == MODE_FWD || mode_now == MODE_LEFT_FWD ||
                    mode_now == MODE_SPIN_RIGHT)) l[1] = 1'b0;
        if (ron && (mode_now == MODE_REV || mode_now == MODE_RIGHT_REV ||
                    mode_now == MODE_SPIN_RIGHT)) l[2] = 1'b0;
        if (ron && (mode_now == MODE_FWD || mode_now == MODE_RIGHT_FWD ||
                    mode_now == MODE_SPIN_LEFT)) l[3] = 1'b0;
        return l;
    endfunction

    task automatic predict_drive(input logic [1:0] cmd, input logic [39:0] d);
        logic [3:0]  code;
        logic [14:0] lim;
        int          spd, rate, acc, inner;
        result_t     r;
        code = d[3:0];
        spd  = pct_limit(d[10:4]);
        rate = pct_limit(d[17:11]);
        acc  = pct_limit(d[24:18]);
        lim  = d[39:25];
        if (cmd == CMD_TICK) begin
            n_tick++;
            pwm_phase = (pwm_phase >= PHASE_TOP) ? 7'd0 : pwm_phase + 7'd1;
            r.lines = line_pattern();
            if (pwm_phase % MS_TICKS == 0) begin
                if (ms_count != 16'd0 && ms_count != 16'hFFFF) ms_count++;
                if (ramping) begin
                    ramp_tick = ramp_tick + 7'd1;
                    if (ramp_tick >= ramp_period) begin
                        ramp_tick = '0;
                        if (ramp_idx < RAMP_LAST) ramp_idx++;
                        duty_l = 7'((5 + int'(ramp_idx)) * int'(ramp_goal) / int'(RAMP_DEN));
                        duty_r = duty_l;
                        if (ramp_idx >= RAMP_LAST) begin
                            ramping = 1'b0;
                            n_ramp++;
                        end
                    end
                end
            end
            if (stop_armed && ms_count > ms_limit) begin
                ms_count   = '0;
                ms_limit   = '0;
                mode_now   = MODE_STOP;
                stop_armed = 1'b0;
                n_autostop++;
            end
        end else begin
            if (cmd == CMD_MOTION) begin
                n_motion++;
                inner = spd * (int'(LEVEL_MAX) - rate) / int'(LEVEL_MAX);
                if (code <= CODE_MODE_MAX) begin
                    mode_now = code;
                    if (ms_count != 16'd0) ms_count = 16'd1;
                    if (acc != 0) begin
                        ramping     = 1'b1;
                        ramp_idx    = '0;
                        ramp_tick   = '0;
                        ramp_period = 7'(int'(RAMP_BASE) - acc);
                        ramp_goal   = 7'(spd);
                        duty_l      = 7'(5 * spd / int'(RAMP_DEN));
                    end else begin
                        ramping = 1'b0;
                        duty_l  = 7'(spd);
                    end
                    duty_r = duty_l;
                end else if (code <= CODE_CURVE_LR) begin
                    ramping  = 1'b0;
                    mode_now = (code <= CODE_CURVE_LF) ? MODE_FWD : MODE_REV;
                    if (code == CODE_CURVE_RF || code == CODE_CURVE_RR) begin
                        duty_l = 7'(spd);
                        duty_r = 7'(inner);
                    end else begin
                        duty_l = 7'(inner);
                        duty_r = 7'(spd);
                    end
                end else begin
                    mode_now = MODE_STOP;
                end
            end else if (cmd == CMD_ARM) begin
                n_arm++;
                ms_limit   = (lim == '0) ? {1'b0, DEFAULT_LIMIT} : {1'b0, lim};
                ms_count   = 16'd1;
                stop_armed = 1'b1;
            end
            if (mode_now == MODE_STOP) begin
                duty_l  = '0;
                duty_r  = '0;
                ramping = 1'b0;
            end
            r.lines = line_pattern();
        end
        if (mode_now == MODE_STOP) begin
            duty_l  = '0;
            duty_r  = '0;
            ramping = 1'b0;
        end
        r.mode  = mode_now;
        r.left  = duty_l;
        r.right = duty_r;
        r.armed = stop_armed;
        drive_expect_q.push_back(r);
    endtask

    task automatic add_raw(input logic [1:0] cmd, input logic [39:0] data);
        cmd_item_t it;
        it.cmd  = cmd;
        it.data = data;
        pending_q.push_back(it);
    endtask

    task automatic add_motion(input int code, input int spd, input int rate, input int acc);
        add_raw(CMD_MOTION, {15'($urandom()), 7'(acc), 7'(rate), 7'(spd), 4'(code)});
    endtask

    task automatic add_arm(input int lim);
        add_raw(CMD_ARM, {15'(lim), 25'($urandom())});
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_raw(CMD_TICK, 40'({$urandom(), $urandom()}));
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_drive(s_axis_tuser, s_axis_tdata);
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_q.pop_front();
                    s_axis_tuser  <= nxt.cmd;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with one long hold-off to fill the pipeline
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            err_cnt++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        result_t exp_r, got_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_r = result_t'(m_axis_tdata[22:0]);
            if (drive_expect_q.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                err_cnt++;
            end else begin
                exp_r = drive_expect_q.pop_front();
                check_field("drive_lines", exp_r.lines, got_r.lines);
                check_field("drive_mode", exp_r.mode, got_r.mode);
                check_field("left_level", exp_r.left, got_r.left);
                check_field("right_level", exp_r.right, got_r.right);
                check_field("timer_armed", exp_r.armed, got_r.armed);
                check_field("pad", 16'd0, m_axis_tdata[23]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("dual_motor_pwm_mode_controller_unit verification failed");
            $finish;
        end
    end

    initial begin
        int n_directed;
        int sel;

        // directed: clamps, every mode, curves, stop codes, unused command, arm limits
        add_motion(MODE_FWD, 127, 0, 0);
        add_ticks(2);
        add_motion(MODE_REV, 100, 127, 0);
        add_motion(MODE_LEFT_FWD, 0, 0, 0);
        add_motion(MODE_RIGHT_FWD, 55, 0, 0);
        add_motion(MODE_RIGHT_REV, 101, 0, 0);
        add_motion(MODE_LEFT_REV, 1, 0, 0);
        add_motion(MODE_SPIN_RIGHT, 70, 0, 0);
        add_motion(MODE_SPIN_LEFT, 99, 0, 0);
        add_motion(MODE_STOP, 127, 127, 127);
        add_motion(CODE_CURVE_RF, 80, 0, 0);
        add_motion(CODE_CURVE_LF, 127, 127, 0);
        add_motion(CODE_CURVE_RR, 90, 100, 127);
        add_motion(CODE_CURVE_LR, 64, 50, 0);
        add_motion(13, 50, 50, 0);
        add_motion(MODE_FWD, 60, 0, 0);
        add_motion(14, 50, 50, 0);
        add_motion(15, 127, 127, 127);
        add_raw(CMD_UNUSED, '1);
        add_arm(0);
        add_arm(32767);
        add_motion(MODE_SPIN_LEFT, 127, 0, 127);
        add_motion(MODE_FWD, 100, 0, 1);
        n_directed = pending_q.size();

        // random scenarios: ramps, auto-stop runs, steady/curve runs, noise
        while (pending_q.size() < n_directed + RANDOM_ITEMS) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                add_motion($urandom_range(1, 8), $urandom_range(0, 127), $urandom_range(0, 127),
                           ($urandom_range(9) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(98, 127));
                add_ticks($urandom_range(15, 100));
            end else if (sel < 60) begin
                add_arm(($urandom_range(9) == 0) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 5));
                if ($urandom_range(1)) begin
                    add_motion($urandom_range(0, 15), $urandom_range(0, 127),
                               $urandom_range(0, 127),
                               $urandom_range(1) ? 0 : $urandom_range(0, 127));
                end
                add_ticks($urandom_range(10, 80));
            end else if (sel < 85) begin
                add_motion($urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(1) ? 0 : $urandom_range(0, 127));
                add_ticks($urandom_range(5, 60));
            end else begin
                repeat ($urandom_range(1, 6))
                    add_raw(2'($urandom_range(0, 3)), 40'({$urandom(), $urandom()}));
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (drive_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d transactions: %0d ticks, %0d motion, %0d arm, %0d other",
                 sent_cnt, n_tick, n_motion, n_arm, sent_cnt - n_tick - n_motion - n_arm);
        $display("Auto-stops fired: %0d, ramps completed: %0d, errors: %0d",
                 n_autostop, n_ramp, err_cnt);
        if (err_cnt == 0) begin
            $display("dual_motor_pwm_mode_controller_unit verification clean");
        end else begin
            $display("dual_motor_pwm_mode_controller_unit verification failed");
        end
        $finish;
    end

endmodule
